// ----- src/htd_pkg.sv -----
// Shared types and codes for the Huffman tree-walk decoder.
package htd_pkg;

  localparam int IDX_W    = 9;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_BIT  = 2'd1,
    REQ_END  = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SYMBOL     = 3'd1,
    ST_NO_LEFT    = 3'd2,
    ST_NO_RIGHT   = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_CLEAN      = 3'd5
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic             left_present;
    logic [IDX_W-1:0] left_child;
    logic             right_present;
    logic [IDX_W-1:0] right_child;
    logic             code_bit;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    symbol;
  } out_word_t;

endpackage

// ----- src/htd_node_mem.sv -----
// Node table: one write port and one registered read port.
module htd_node_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int WIDTH  = 29
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // The read word holds until the next read so a stalled result keeps its data.
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/htd_walker.sv -----
// Tree-walk engine: node table access, current node, root register, result register.
module htd_walker #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8,
  parameter int ADDR_W      = 9,
  parameter int ENT_W       = 29
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [htd_pkg::IDX_W-1:0] cfg_data,
  input  logic                     req_valid,
  input  htd_pkg::in_word_t        req,
  output logic                     req_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output htd_pkg::out_word_t       out_data,
  output logic                     mem_wr_en,
  output logic [ADDR_W-1:0]        mem_wr_addr,
  output logic [ENT_W-1:0]         mem_wr_data,
  output logic                     mem_rd_en,
  output logic [ADDR_W-1:0]        mem_rd_addr,
  input  logic [ENT_W-1:0]         mem_rd_data
);

  // Entry layout: {leaf, symbol, has_left, left, has_right, right}.
  localparam int R_LO    = 0;
  localparam int HR_POS  = htd_pkg::IDX_W;
  localparam int L_LO    = htd_pkg::IDX_W + 1;
  localparam int HL_POS  = 2 * htd_pkg::IDX_W + 1;
  localparam int SYM_LO  = 2 * htd_pkg::IDX_W + 2;
  localparam int LEAF_POS = SYM_LO + SYMBOL_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CUR,
    S_CHILD
  } state_t;

  state_t                    state_r, state_nxt;
  logic [htd_pkg::IDX_W-1:0] root_r, root_nxt;
  logic [htd_pkg::IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [htd_pkg::IDX_W-1:0] child_idx_r, child_idx_nxt;
  logic [ENT_W-1:0]          cache_r, cache_nxt;
  logic                      cache_ok_r, cache_ok_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic                      out_valid_r;
  htd_pkg::out_word_t        out_data_r;

  logic                      slot_free;
  logic                      res_en;
  htd_pkg::out_word_t        res;
  logic [ENT_W-1:0]          cur_ent;
  logic                      go_right;
  logic                      child_has;
  logic [htd_pkg::IDX_W-1:0] child_idx;
  logic                      child_ok;
  logic                      do_step;
  logic                      rd_leaf;
  logic                      load_in_range;
  logic                      cur_in_range;

  assign slot_free     = !out_valid_r || !out_stall;
  assign go_right      = req.code_bit;
  assign cur_ent       = (state_r == S_CUR) ? (rd_ok_r ? mem_rd_data : '0) : cache_r;
  assign child_has     = go_right ? cur_ent[HR_POS] : cur_ent[HL_POS];
  assign child_idx     = go_right ? cur_ent[R_LO +: htd_pkg::IDX_W]
                                  : cur_ent[L_LO +: htd_pkg::IDX_W];
  assign child_ok      = child_has && (32'(child_idx) < NODE_COUNT);
  assign rd_leaf       = mem_rd_data[LEAF_POS] || (!mem_rd_data[HL_POS] && !mem_rd_data[HR_POS]);
  assign load_in_range = 32'(req.node_index) < NODE_COUNT;
  assign cur_in_range  = 32'(cur_idx_r) < NODE_COUNT;

  assign mem_wr_addr = ADDR_W'(req.node_index);
  assign mem_wr_data = {req.node_is_leaf, SYMBOL_BITS'(req.node_symbol), req.left_present,
                        req.left_child, req.right_present, req.right_child};

  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    cur_idx_nxt   = cur_idx_r;
    child_idx_nxt = child_idx_r;
    cache_nxt     = cache_r;
    cache_ok_nxt  = cache_ok_r;
    rd_ok_nxt     = rd_ok_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ADDR_W'(cur_idx_r);
    res_en        = 1'b0;
    res           = '0;
    req_take      = 1'b0;
    do_step       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.req_type)
            htd_pkg::REQ_LOAD: begin
              if (slot_free) begin
                res_en   = 1'b1;
                req_take = 1'b1;
                if (load_in_range) begin
                  mem_wr_en = 1'b1;
                  if (req.node_index == cur_idx_r) begin
                    cache_ok_nxt = 1'b0;
                  end
                end
              end
            end
            htd_pkg::REQ_BIT: begin
              if (cache_ok_r) begin
                do_step = 1'b1;
              end else begin
                mem_rd_en = 1'b1;
                rd_ok_nxt = cur_in_range;
                state_nxt = S_CUR;
              end
            end
            htd_pkg::REQ_END: begin
              if (slot_free) begin
                res_en     = 1'b1;
                req_take   = 1'b1;
                res.status = (cur_idx_r == root_r) ? htd_pkg::ST_CLEAN
                                                   : htd_pkg::ST_INCOMPLETE;
                if (cur_idx_r != root_r) begin
                  cur_idx_nxt  = root_r;
                  cache_ok_nxt = 1'b0;
                end
              end
            end
            default: begin
              if (slot_free) begin
                res_en   = 1'b1;
                req_take = 1'b1;
              end
            end
          endcase
        end
      end
      S_CUR: begin
        // The current node's entry arrives now; keep it for later bits.
        cache_nxt    = cur_ent;
        cache_ok_nxt = 1'b1;
        do_step      = 1'b1;
      end
      S_CHILD: begin
        if (slot_free) begin
          res_en    = 1'b1;
          req_take  = 1'b1;
          state_nxt = S_IDLE;
          if (rd_leaf) begin
            res.status   = htd_pkg::ST_SYMBOL;
            res.symbol   = htd_pkg::SYM_W'(mem_rd_data[SYM_LO +: SYMBOL_BITS]);
            cur_idx_nxt  = root_r;
            cache_ok_nxt = 1'b0;
          end else begin
            cur_idx_nxt  = child_idx_r;
            cache_nxt    = mem_rd_data;
            cache_ok_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_step) begin
      if (!child_ok) begin
        if (slot_free) begin
          res_en       = 1'b1;
          req_take     = 1'b1;
          res.status   = go_right ? htd_pkg::ST_NO_RIGHT : htd_pkg::ST_NO_LEFT;
          cur_idx_nxt  = root_r;
          cache_ok_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end else begin
        mem_rd_en     = 1'b1;
        mem_rd_addr   = ADDR_W'(child_idx);
        rd_ok_nxt     = 1'b1;
        child_idx_nxt = child_idx;
        state_nxt     = S_CHILD;
      end
    end

    if (cfg_we) begin
      root_nxt     = cfg_data;
      cur_idx_nxt  = cfg_data;
      cache_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      cur_idx_r   <= '0;
      cache_ok_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      root_r     <= root_nxt;
      cur_idx_r  <= cur_idx_nxt;
      cache_ok_r <= cache_ok_nxt;
      rd_ok_r    <= rd_ok_nxt;
      if (res_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    child_idx_r <= child_idx_nxt;
    cache_r     <= cache_nxt;
    if (res_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every word taken from the input produces exactly one result in the same cycle.
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_take == res_en)
    else $error("input word taken without a result or result without a word");

  // A child read is never issued while the child entry is being consumed.
  a_child_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHILD |-> !mem_rd_en)
    else $error("read issued while child entry pending");

  // After a decoded symbol the walk is back at the root.
  a_sym_root: assert property (@(posedge clk) disable iff (!rst_n)
    res_en && res.status == htd_pkg::ST_SYMBOL && !cfg_we |=> cur_idx_r == $past(root_r))
    else $error("walk did not return to root after a symbol");

  // The symbol field is zero unless a symbol is reported.
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != htd_pkg::ST_SYMBOL |-> out_data_r.symbol == '0)
    else $error("symbol field set without a symbol status");

endmodule

// ----- src/huffman_tree_decoder.sv -----
// Top level of the Huffman tree-walk decoder: input register, walker and node table.
//
//   Channel  Direction  Ports                          Word
//   in       input      in_valid, in_stall, in_data    htd_pkg::in_word_t
//   out      output     out_valid, out_stall, out_data htd_pkg::out_word_t
//   cfg      input      cfg_we, cfg_data               root node index
//
// Load, end and unused words are answered from the idle state.
// A bit while the walk is below the root steps from the current entry held in a register
// and reads the child entry; the first bit of each code first reads the current entry too.
// A bit that finds no child answers without the child read.
// Reset clears the control state and the root register; the node table is not cleared.
// A stalled output holds its word; one further input word waits in the input register.
module huffman_tree_decoder #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [htd_pkg::IDX_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  htd_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output htd_pkg::out_word_t        out_data
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam int ENT_W  = 2 * htd_pkg::IDX_W + 3 + SYMBOL_BITS;

  logic              buf_valid_r;
  htd_pkg::in_word_t buf_r;
  logic              take;
  logic              accept;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0]  mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0]  mem_rd_data;

  assign in_stall = buf_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= accept || (buf_valid_r && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= in_data;
    end
  end

  htd_walker #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS),
    .ADDR_W      (ADDR_W),
    .ENT_W       (ENT_W)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req_valid   (buf_valid_r),
    .req         (buf_r),
    .req_take    (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  htd_node_mem #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (ADDR_W),
    .WIDTH  (ENT_W)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- tb/huffman_tree_decoder_checker.sv -----
`timescale 1ns / 100ps
// Decoder checker: watches all ports, keeps its own node table and walk state, compares results.
module huffman_tree_decoder_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [htd_pkg::IDX_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  htd_pkg::in_word_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  htd_pkg::out_word_t        out_data,
  output int                        mismatches,
  output int                        pending
);

  localparam int IDX_W = htd_pkg::IDX_W;
  localparam int SYM_W = htd_pkg::SYM_W;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic             has_left;
    logic [IDX_W-1:0] left_idx;
    logic             has_right;
    logic [IDX_W-1:0] right_idx;
  } tree_node_t;

  tree_node_t         code_tree [2**IDX_W];
  logic [IDX_W-1:0]   walk_node;
  logic [IDX_W-1:0]   root_node;
  htd_pkg::out_word_t decoded_q [$];
  int                 errors = 0;

  // Applies one input word to the tree state and returns the result word it should produce.
  function automatic htd_pkg::out_word_t decode_word(htd_pkg::in_word_t w);
    tree_node_t         cur;
    tree_node_t         child;
    logic [IDX_W-1:0]   next;
    logic               present;
    htd_pkg::out_word_t r;
    r        = '0;
    r.status = htd_pkg::ST_OK;
    case (w.req_type)
      htd_pkg::REQ_LOAD: begin
        code_tree[w.node_index] = '{w.node_is_leaf, w.node_symbol, w.left_present,
                                    w.left_child, w.right_present, w.right_child};
      end
      htd_pkg::REQ_BIT: begin
        cur     = code_tree[walk_node];
        present = w.code_bit ? cur.has_right : cur.has_left;
        next    = w.code_bit ? cur.right_idx : cur.left_idx;
        if (!present) begin
          r.status  = w.code_bit ? htd_pkg::ST_NO_RIGHT : htd_pkg::ST_NO_LEFT;
          walk_node = root_node;
        end else begin
          child = code_tree[next];
          // A node without children can only be a leaf, whatever its flag says.
          if (child.leaf || (!child.has_left && !child.has_right)) begin
            r.status  = htd_pkg::ST_SYMBOL;
            r.symbol  = child.sym;
            walk_node = root_node;
          end else begin
            walk_node = next;
          end
        end
      end
      htd_pkg::REQ_END: begin
        r.status  = (walk_node == root_node) ? htd_pkg::ST_CLEAN : htd_pkg::ST_INCOMPLETE;
        walk_node = root_node;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    htd_pkg::out_word_t want;
    if (!rst_n) begin
      walk_node = '0;
      root_node = '0;
      decoded_q.delete();
    end else begin
      // Results are checked before new words are predicted, so a word cannot match itself.
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $error("result word with nothing expected: status %0d, symbol %0d",
                 out_data.status, out_data.symbol);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.status !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
          end
          if (out_data.symbol !== want.symbol) begin
            errors++;
            $error("symbol: expected %0d, actual %0d", want.symbol, out_data.symbol);
          end
        end
      end
      if (cfg_we) begin
        root_node = cfg_data;
        walk_node = cfg_data;
      end
      if (in_valid && !in_stall) decoded_q = {decoded_q, decode_word(in_data)};
    end
    pending    <= decoded_q.size();
    mismatches <= errors;
  end

endmodule

// ----- tb/huffman_tree_decoder_test.sv -----
`timescale 1ns / 100ps
// Decoder testbench top: clock, reset, tree loads and code streams, verdict.
module huffman_tree_decoder_test;

  localparam int IDX_W       = htd_pkg::IDX_W;
  localparam int SYM_W       = htd_pkg::SYM_W;
  localparam int NODES       = 2**IDX_W;
  localparam int ITEM_GOAL   = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_FROM   = 3000;
  localparam int CALM_TO     = 6000;
  localparam int MAX_TREE    = 127;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [IDX_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  htd_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  htd_pkg::out_word_t out_data;
  int                 mismatches;
  int                 pending;
  int unsigned        cycle_count = 0;
  int unsigned        item_count  = 0;
  bit                 written [NODES];

  // Tree of the current phase in growth order; children always come after their parent.
  logic [IDX_W-1:0] tree_idx    [MAX_TREE];
  bit               tree_inner  [MAX_TREE];
  int               tree_left   [MAX_TREE];
  int               tree_right  [MAX_TREE];
  int               tree_parent [MAX_TREE];
  int               tree_size;

  // Neither side idles inside this window.
  wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 27);

  huffman_tree_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  huffman_tree_decoder_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  function automatic htd_pkg::in_word_t junk_word(htd_pkg::req_t req);
    logic [63:0]       raw;
    htd_pkg::in_word_t w;
    raw        = {$urandom, $urandom};
    w          = raw[$bits(htd_pkg::in_word_t)-1:0];
    w.req_type = req;
    return w;
  endfunction

  function automatic htd_pkg::in_word_t load_word(logic [IDX_W-1:0] idx, logic leaf,
                                                  logic [SYM_W-1:0] sym, logic lp,
                                                  logic [IDX_W-1:0] lc, logic rp,
                                                  logic [IDX_W-1:0] rc);
    htd_pkg::in_word_t w;
    w               = junk_word(htd_pkg::REQ_LOAD);
    w.node_index    = idx;
    w.node_is_leaf  = leaf;
    w.node_symbol   = sym;
    w.left_present  = lp;
    w.left_child    = lc;
    w.right_present = rp;
    w.right_child   = rc;
    return w;
  endfunction

  function automatic htd_pkg::in_word_t bit_word(logic b);
    htd_pkg::in_word_t w;
    w          = junk_word(htd_pkg::REQ_BIT);
    w.code_bit = b;
    return w;
  endfunction

  // A child may only be marked present when its entry holds data, so no walk reads an
  // empty entry.
  function automatic void pick_child(output logic present, output logic [IDX_W-1:0] idx);
    idx     = IDX_W'($urandom_range(NODES - 1));
    present = written[idx] && ($urandom_range(1) != 0);
  endfunction

  // Valid is only lowered for a gap, so back-to-back words keep it high.
  task automatic send_word(input htd_pkg::in_word_t w);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 27);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.req_type == htd_pkg::REQ_LOAD) written[w.node_index] = 1'b1;
    if (w.req_type != htd_pkg::REQ_NOP) item_count++;
  endtask

  task automatic send_bits(input int n, input logic [31:0] pattern);
    int j;
    for (j = n - 1; j >= 0; j--) send_word(bit_word(pattern[j]));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] idx);
    wait_drained();
    cfg_data <= idx;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_noise_load();
    logic             lp;
    logic             rp;
    logic [IDX_W-1:0] lc;
    logic [IDX_W-1:0] rc;
    pick_child(lp, lc);
    pick_child(rp, rc);
    send_word(load_word(IDX_W'($urandom_range(NODES - 1)), 1'($urandom_range(1)),
                        SYM_W'($urandom_range(255)), lp, lc, rp, rc));
  endtask

  // Grows a random full binary tree by splitting leaves, places it at random indices and
  // loads it bottom-up. Now and then an inner node loses one child.
  task automatic build_tree(input int leaves);
    bit               taken [NODES];
    int               j;
    int               k;
    int               pick;
    logic             leaf_flag;
    logic             lp;
    logic             rp;
    logic [IDX_W-1:0] lc;
    logic [IDX_W-1:0] rc;
    tree_size      = 1;
    tree_inner[0]  = 1'b0;
    tree_parent[0] = -1;
    for (j = 1; j < leaves; j++) begin
      do k = $urandom_range(tree_size - 1); while (tree_inner[k]);
      tree_inner[k]  = 1'b1;
      tree_left[k]   = tree_size;
      tree_right[k]  = tree_size + 1;
      tree_inner[tree_size]      = 1'b0;
      tree_inner[tree_size + 1]  = 1'b0;
      tree_parent[tree_size]     = k;
      tree_parent[tree_size + 1] = k;
      tree_size += 2;
    end
    for (j = 0; j < tree_size; j++) begin
      do pick = $urandom_range(NODES - 1); while (taken[pick]);
      taken[pick] = 1'b1;
      tree_idx[j] = IDX_W'(pick);
    end
    for (j = tree_size - 1; j >= 0; j--) begin
      if ($urandom_range(19) == 0) begin
        send_word(junk_word(htd_pkg::req_t'($urandom_range(1, 3))));
      end
      if (tree_inner[j]) begin
        k = ($urandom_range(11) == 0) ? $urandom_range(1, 2) : 0;
        send_word(load_word(tree_idx[j], 1'b0, SYM_W'($urandom_range(255)),
                            k != 1, tree_idx[tree_left[j]],
                            k != 2, tree_idx[tree_right[j]]));
      end else begin
        leaf_flag = 1'($urandom_range(1));
        if (leaf_flag) begin
          pick_child(lp, lc);
          pick_child(rp, rc);
        end else begin
          lp = 1'b0;
          rp = 1'b0;
          lc = IDX_W'($urandom_range(NODES - 1));
          rc = IDX_W'($urandom_range(NODES - 1));
        end
        send_word(load_word(tree_idx[j], leaf_flag, SYM_W'($urandom_range(255)),
                            lp, lc, rp, rc));
      end
    end
  endtask

  // Sends the code of one leaf, or a random prefix of it followed by an end word.
  task automatic send_code(input int leaf_k, input bit cut_short);
    bit path [MAX_TREE];
    int n;
    int k;
    int stop;
    n = 0;
    k = leaf_k;
    while (tree_parent[k] >= 0) begin
      path[n] = (tree_right[tree_parent[k]] == k);
      n++;
      k = tree_parent[k];
    end
    stop = cut_short ? $urandom_range(n) : 0;
    for (k = n - 1; k >= stop; k--) send_word(bit_word(path[k]));
    if (cut_short) send_word(junk_word(htd_pkg::REQ_END));
  endtask

  task automatic run_phase();
    int leaves;
    int codes;
    int j;
    int k;
    int choice;
    leaves = ($urandom_range(9) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 12);
    build_tree(leaves);
    write_root(($urandom_range(7) == 0) ? tree_idx[$urandom_range(tree_size - 1)]
                                        : tree_idx[0]);
    codes = $urandom_range(8, 40);
    for (j = 0; j < codes; j++) begin
      choice = $urandom_range(99);
      if (choice < 4) begin
        send_word(junk_word(htd_pkg::REQ_NOP));
      end else if (choice < 7) begin
        send_noise_load();
      end else if (choice < 11) begin
        send_word(junk_word(htd_pkg::REQ_END));
      end else if (choice < 16) begin
        send_bits($urandom_range(1, 6), $urandom);
      end else begin
        do k = $urandom_range(tree_size - 1); while (tree_inner[k]);
        send_code(k, choice < 26);
      end
    end
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Known tree at root 0: 0 -> (511, 1), 1 -> (2, none), 2 -> (none, 3), 3 childless.
    // Node 511 is a flagged leaf that still has both children.
    send_word(junk_word(htd_pkg::REQ_END));
    send_word(junk_word(htd_pkg::REQ_NOP));
    send_word(load_word(9'd3, 1'b0, 8'h00, 1'b0, 9'd511, 1'b0, 9'd0));
    send_word(load_word(9'd2, 1'b0, 8'hA5, 1'b0, 9'd0, 1'b1, 9'd3));
    send_word(load_word(9'd1, 1'b0, 8'h5A, 1'b1, 9'd2, 1'b0, 9'd511));
    send_word(load_word(9'd511, 1'b1, 8'hFF, 1'b1, 9'd1, 1'b1, 9'd2));
    send_word(load_word(9'd0, 1'b0, 8'h00, 1'b1, 9'd511, 1'b1, 9'd1));
    send_bits(1, 'b0);
    send_bits(3, 'b101);
    send_bits(2, 'b11);
    send_bits(3, 'b100);
    send_bits(1, 'b1);
    send_word(junk_word(htd_pkg::REQ_END));
    send_word(junk_word(htd_pkg::REQ_END));
    write_root(9'd511);
    send_bits(2, 'b11);
    send_bits(1, 'b0);
    send_word(junk_word(htd_pkg::REQ_END));
    // A root write in the middle of a code puts the walk back at the root.
    send_bits(1, 'b1);
    write_root(9'd0);
    send_word(junk_word(htd_pkg::REQ_END));

    while (item_count < ITEM_GOAL) run_phase();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
